>>> rtl/core/ffba_pkg.sv
// shared types and constants of the first-fit bitmap allocator
package ffba_pkg;

  // map geometry
  localparam int WORD_W        = 32;
  localparam int MAP_UNITS_DEF = 1024;

  // beat field widths
  localparam int START_W = 10;
  localparam int SIZE_W  = 11;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // request beat
  typedef struct packed {
    logic               operation;
    logic [START_W-1:0] block_start;
    logic [SIZE_W-1:0]  request_size;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] run_start;
  } out_beat_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } state_t;

endpackage

>>> rtl/core/ffba_ram.sv
// generic single-write, single-read ram with registered read data
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/first_fit_bitmap_allocator_unit.sv
// first-fit contiguous bitmap allocator: map ram, word scanner and run marker
//
// Keeps one occupancy bit per unit in a ram of 32-bit words. After reset a
// clearing pass writes every word to zero, one word a cycle, and no request
// is taken until it ends. An allocate reads the map one word a cycle from
// unit 0 and stops at the first word that completes a free run of the
// requested size, then rewrites the words of that run one a cycle. A free
// rewrites the words of its clipped run the same way. A refused request
// goes straight to the result without touching the map. One request is in
// work at a time; the next one is taken as soon as the result sits in the
// output register, whether or not it has been taken.
module first_fit_bitmap_allocator_unit #(
  parameter int MAP_UNITS = ffba_pkg::MAP_UNITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::out_beat_t out_data
);

  localparam int W   = ffba_pkg::WORD_W;
  localparam int WB  = $clog2(W);
  localparam int NW  = (MAP_UNITS + W - 1) / W;
  localparam int AWD = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW  = $clog2(MAP_UNITS + 1);
  localparam int XW  = ((CW > ffba_pkg::SIZE_W) ? CW : ffba_pkg::SIZE_W) + 1;
  localparam int PW  = WB + 1;
  localparam logic [XW-1:0]  MAP_X  = XW'(MAP_UNITS);
  localparam logic [AWD-1:0] LAST_W = AWD'(NW - 1);

  ffba_pkg::state_t    state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [XW-1:0]       size_r, size_nxt;
  logic [XW-1:0]       lo_r, lo_nxt;
  logic [XW-1:0]       hi_r, hi_nxt;
  logic [XW-1:0]       cnt_r, cnt_nxt;
  logic [AWD-1:0]      idx_r, idx_nxt;
  ffba_pkg::out_beat_t res_r, res_nxt;
  ffba_pkg::out_beat_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // ram ports
  logic           ram_we;
  logic [AWD-1:0] ram_raddr;
  logic [W-1:0]   ram_wdata;
  logic [W-1:0]   ram_rdata;

  // datapath signals
  logic [XW-1:0]  base;
  logic [W-1:0]   used;
  logic [PW-1:0]  pos [W];
  logic [W-1:0]   hit;
  logic           hit_any;
  logic [WB-1:0]  hit_sel;
  logic [XW-1:0]  run_len;
  logic [XW-1:0]  alloc_lo;
  logic [XW-1:0]  cnt_step;
  logic [W-1:0]   run_mask;
  logic           mark_last;
  logic [XW-1:0]  req_size;
  logic [XW-1:0]  req_start;
  logic [XW-1:0]  req_end;

  ffba_ram #(
    .WIDTH(W),
    .DEPTH(NW)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // unit index of bit 0 of the word in hand
  assign base = XW'({idx_r, {WB{1'b0}}});

  // used bits of the word, units past the map count as used
  always_comb begin
    for (int j = 0; j < W; j++) begin
      used[j] = ram_rdata[j] | ((base + XW'(j)) >= MAP_X);
    end
  end

  // position just above the highest used bit at or below each bit
  always_comb begin
    for (int j = 0; j < W; j++) begin
      pos[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (used[k]) begin
          pos[j] = PW'(k + 1);
        end
      end
    end
  end

  // free run length ending at each bit, carrying the run from earlier words
  always_comb begin
    for (int j = 0; j < W; j++) begin
      run_len = '0;
      if (pos[j] == '0) begin
        run_len = cnt_r + XW'(j + 1);
      end else begin
        run_len = XW'(PW'(j + 1) - pos[j]);
      end
      hit[j] = !used[j] && (run_len >= size_r);
    end
  end

  // lowest bit that completes a long enough run
  always_comb begin
    hit_any = |hit;
    hit_sel = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_sel = WB'(j);
      end
    end
  end

  assign alloc_lo = base + XW'(hit_sel) + XW'(1) - size_r;

  // free run left open at the top of the word
  assign cnt_step = (pos[W-1] == '0) ? (cnt_r + XW'(W))
                                     : XW'(PW'(W) - pos[W-1]);

  // bits of the word in hand that lie in the run being marked
  always_comb begin
    for (int j = 0; j < W; j++) begin
      run_mask[j] = ((base + XW'(j)) >= lo_r) && ((base + XW'(j)) < hi_r);
    end
  end

  assign mark_last = (((hi_r - XW'(1)) >> WB) == XW'(idx_r));

  // request fields widened for range arithmetic
  assign req_size  = XW'(in_data.request_size);
  assign req_start = XW'(in_data.block_start);
  assign req_end   = ((req_start + req_size) > MAP_X) ? MAP_X : (req_start + req_size);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    size_r <= size_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // sequencer: next state, ram control and result
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    ram_raddr     = idx_r;

    case (state_r)
      // zero the map after reset
      ffba_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_W) begin
          idx_nxt   = '0;
          state_nxt = ffba_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + AWD'(1);
        end
      end

      // take a request beat and sort out refusals
      ffba_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;
        if (in_valid) begin
          op_nxt   = in_data.operation;
          size_nxt = req_size;
          res_nxt  = '0;
          if (in_data.operation == ffba_pkg::OP_ALLOC) begin
            if (req_size == '0 || req_size > MAP_X) begin
              state_nxt = ffba_pkg::ST_RESP;
            end else begin
              idx_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ffba_pkg::ST_SCAN;
            end
          end else begin
            if (req_size == '0 || req_start >= MAP_X) begin
              state_nxt = ffba_pkg::ST_RESP;
            end else begin
              lo_nxt          = req_start;
              hi_nxt          = req_end;
              idx_nxt         = AWD'(req_start >> WB);
              res_nxt.granted = 1'b1;
              state_nxt       = ffba_pkg::ST_MARK_RD;
            end
          end
        end
      end

      // one map word a cycle, next word read in flight
      ffba_pkg::ST_SCAN: begin
        ram_raddr = idx_r + AWD'(1);
        if (hit_any) begin
          lo_nxt            = alloc_lo;
          hi_nxt            = alloc_lo + size_r;
          idx_nxt           = AWD'(alloc_lo >> WB);
          res_nxt.granted   = 1'b1;
          res_nxt.run_start = alloc_lo[ffba_pkg::START_W-1:0];
          state_nxt         = ffba_pkg::ST_MARK_RD;
        end else if (idx_r == LAST_W) begin
          state_nxt = ffba_pkg::ST_RESP;
        end else begin
          cnt_nxt = cnt_step;
          idx_nxt = idx_r + AWD'(1);
        end
      end

      // read the first word of the run
      ffba_pkg::ST_MARK_RD: begin
        ram_raddr = idx_r;
        state_nxt = ffba_pkg::ST_MARK_WR;
      end

      // write back the word in hand, read the next one
      ffba_pkg::ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (op_r == ffba_pkg::OP_ALLOC) ? (ram_rdata | run_mask)
                                                 : (ram_rdata & ~run_mask);
        ram_raddr = idx_r + AWD'(1);
        if (mark_last) begin
          state_nxt = ffba_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + AWD'(1);
        end
      end

      // hand the result to the output register once it is free
      ffba_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          idx_nxt       = '0;
          state_nxt     = ffba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffba_pkg::ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> tb/sv/first_fit_bitmap_allocator_unit_tb.sv
// testbench for the first-fit bitmap allocator: random requests checked against a bitmap model
`timescale 1ns / 1ps

module first_fit_bitmap_allocator_unit_tb;

  localparam int MAP_UNITS   = ffba_pkg::MAP_UNITS_DEF;
  localparam int START_W     = ffba_pkg::START_W;
  localparam int SIZE_W      = ffba_pkg::SIZE_W;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    int unsigned base;
    int unsigned len;
  } run_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ffba_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ffba_pkg::out_beat_t out_data;

  // request beats waiting to be driven, answers waiting to come back
  ffba_pkg::in_beat_t  request_q[$];
  ffba_pkg::out_beat_t answer_q[$];
  // model of the occupancy map and the runs granted so far
  bit        unit_used[MAP_UNITS];
  run_t      held_runs[$];

  int        src_idle_pct  = 0;
  int        snk_stall_pct = 0;
  int        hold_req      = 0;
  int        hold_seen     = 0;
  int        hold_left     = 0;
  int        err_count     = 0;
  int        stall_cycles  = 0;
  logic      in_acc        = 1'b0;

  first_fit_bitmap_allocator_unit #(
    .MAP_UNITS(MAP_UNITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // first-fit answer for one request, updating the map model
  function automatic ffba_pkg::out_beat_t first_fit_answer(ffba_pkg::in_beat_t req);
    ffba_pkg::out_beat_t ans;
    run_t        held;
    int unsigned len;
    int unsigned start;
    int unsigned run_len;
    int unsigned run_base;
    int unsigned u;
    bit          found;
    ans      = '0;
    len      = 32'(req.request_size);
    start    = 32'(req.block_start);
    found    = 1'b0;
    run_len  = 0;
    run_base = 0;
    if (req.operation == ffba_pkg::OP_ALLOC) begin
      // lowest start with len free units in a row
      if (len != 0 && len <= MAP_UNITS) begin
        for (u = 0; u < MAP_UNITS && !found; u++) begin
          if (!unit_used[u]) begin
            if (run_len == 0) run_base = u;
            run_len++;
            if (run_len == len) found = 1'b1;
          end else begin
            run_len = 0;
          end
        end
      end
      if (found) begin
        for (u = run_base; u < run_base + len; u++) unit_used[u] = 1'b1;
        held.base = run_base;
        held.len  = len;
        held_runs.push_back(held);
        ans.granted   = 1'b1;
        ans.run_start = run_base[START_W-1:0];
      end
    end else if (len != 0 && start < MAP_UNITS) begin
      // free, clipped at the end of the map
      for (u = start; u < start + len && u < MAP_UNITS; u++) begin
        unit_used[u] = 1'b0;
      end
      ans.granted = 1'b1;
    end
    return ans;
  endfunction

  // random request: mostly allocations and frees of granted runs, some noise
  function automatic ffba_pkg::in_beat_t next_request();
    ffba_pkg::in_beat_t req;
    run_t        held;
    int unsigned pick;
    int unsigned idx;
    pick             = $urandom_range(99);
    req.operation    = ffba_pkg::OP_FREE;
    req.block_start  = START_W'($urandom_range(MAP_UNITS - 1));
    req.request_size = '0;
    if (pick < 45) begin
      req.operation = ffba_pkg::OP_ALLOC;
      idx = $urandom_range(99);
      if (idx < 70)      req.request_size = SIZE_W'($urandom_range(16, 1));
      else if (idx < 90) req.request_size = SIZE_W'($urandom_range(128, 17));
      else if (idx < 95) req.request_size = SIZE_W'($urandom_range(MAP_UNITS, 129));
      else               req.request_size = SIZE_W'($urandom_range(2047));
    end else if (pick < 86 && held_runs.size() > 0) begin
      idx  = $urandom_range(held_runs.size() - 1);
      held = held_runs[idx];
      held_runs.delete(idx);
      req.block_start  = START_W'(held.base);
      req.request_size = SIZE_W'(held.len);
    end else if (pick == 99) begin
      // wipe the whole map now and then
      req.block_start  = '0;
      req.request_size = SIZE_W'(MAP_UNITS);
      held_runs.delete();
    end else begin
      idx = $urandom_range(2);
      if (idx == 0)      req.request_size = '0;
      else if (idx == 1) req.request_size = SIZE_W'($urandom_range(64, 1));
      else               req.request_size = SIZE_W'($urandom_range(2047));
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
  endtask

  task automatic push_req(logic op, int unsigned start, int unsigned size);
    ffba_pkg::in_beat_t req;
    req.operation    = op;
    req.block_start  = start[START_W-1:0];
    req.request_size = size[SIZE_W-1:0];
    request_q.push_back(req);
  endtask

  // feed n random beats with the given idle and stall rates
  task automatic run_phase(int n, int src_pct, int snk_pct, int hold_at);
    int k;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (k = 0; k < n; k++) begin
      while (request_q.size() >= 4) @(negedge clk);
      if (k == hold_at) hold_req++;
      request_q.push_back(next_request());
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: check result beats, then predict for accepted request beats
  always @(posedge clk) begin : monitor_blk
    ffba_pkg::out_beat_t want;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result beat with none pending", 0, 32'(out_data.run_start));
        end else begin
          want = answer_q.pop_front();
          if (out_data.granted !== want.granted)
            report_mismatch("granted", 32'(want.granted), 32'(out_data.granted));
          if (out_data.run_start !== want.run_start)
            report_mismatch("run_start", 32'(want.run_start), 32'(out_data.run_start));
        end
      end
      if (in_valid && in_ready) answer_q.push_back(first_fit_answer(in_data));
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // reset, directed beats, random phases, end of run
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // size zero, whole map, full map, size above the map
    push_req(ffba_pkg::OP_ALLOC, 1023, 0);
    push_req(ffba_pkg::OP_ALLOC, 0, MAP_UNITS);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_FREE, 0, 0);
    push_req(ffba_pkg::OP_FREE, 1023, 2047);
    push_req(ffba_pkg::OP_FREE, 0, MAP_UNITS);
    push_req(ffba_pkg::OP_ALLOC, 0, MAP_UNITS + 1);
    push_req(ffba_pkg::OP_ALLOC, 1023, 2047);
    // runs crossing word boundaries, hole too small for the next run
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 31);
    push_req(ffba_pkg::OP_ALLOC, 0, 33);
    push_req(ffba_pkg::OP_FREE, 0, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 2);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    // free of units already free, last unit
    push_req(ffba_pkg::OP_FREE, 500, 10);
    push_req(ffba_pkg::OP_FREE, 1023, 1);
    push_req(ffba_pkg::OP_FREE, 0, MAP_UNITS);
    // run ending at the last unit
    push_req(ffba_pkg::OP_ALLOC, 512, MAP_UNITS - 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_FREE, 512, 0);
    push_req(ffba_pkg::OP_FREE, 0, 2047);

    run_phase(500, 0, 0, 150);
    run_phase(480, 72, 0, -1);
    run_phase(480, 0, 72, -1);
    run_phase(490, 7, 7, -1);

    // drain
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/first_fit_bitmap_allocator_unit.sv
tb/sv/first_fit_bitmap_allocator_unit_tb.sv
